[rtl/lcpbm_pkg.sv]
// shared types, constants and helpers for the latched chr/prg bank mapper
package lcpbm_pkg;

   localparam int unsigned MAX_PRG_BANKS = 256;
   localparam int unsigned MAX_CHR_BANKS = 32;
   localparam int unsigned QUEUE_DEPTH   = 2;
   localparam int unsigned DIV_STEPS     = 5;

   typedef enum logic [1:0] {
      OP_CPU_READ  = 2'd0,
      OP_CPU_WRITE = 2'd1,
      OP_PPU_READ  = 2'd2,
      OP_PPU_WRITE = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      TGT_NONE    = 2'd0,
      TGT_PRG_ROM = 2'd1,
      TGT_PRG_RAM = 2'd2,
      TGT_CHR     = 2'd3
   } tgt_type;

   typedef enum logic [1:0] {
      CSR_PRG_BANK_COUNT  = 2'd0,
      CSR_CHR_BANK_COUNT  = 2'd1,
      CSR_PRG_RAM_PRESENT = 2'd2
   } csr_index_type;

   localparam logic [2:0] REG_PRG_SELECT   = 3'd2;
   localparam logic [2:0] REG_CHR_LOW_FD   = 3'd3;
   localparam logic [2:0] REG_CHR_LOW_FE   = 3'd4;
   localparam logic [2:0] REG_CHR_HIGH_FD  = 3'd5;
   localparam logic [2:0] REG_CHR_HIGH_FE  = 3'd6;
   localparam logic [2:0] REG_MIRROR       = 3'd7;

   typedef enum logic [3:0] {
      KIND_IGNORE     = 4'd0,
      KIND_OPEN_READ  = 4'd1,
      KIND_RAM_READ   = 4'd2,
      KIND_RAM_WRITE  = 4'd3,
      KIND_PRG_SWITCH = 4'd4,
      KIND_PRG_FIXED  = 4'd5,
      KIND_REG_WRITE  = 4'd6,
      KIND_CHR_READ   = 4'd7,
      KIND_CHR_WRITE  = 4'd8
   } kind_type;

   typedef enum logic [1:0] {
      BACK_IDLE   = 2'd0,
      BACK_DIVIDE = 2'd1,
      BACK_FINISH = 2'd2
   } back_state_type;

   typedef struct packed {
      logic [1:0]  operation;
      logic [15:0] address;
      logic [7:0]  write_data;
   } lcpbm_req_type;

   typedef struct packed {
      logic        handled;
      logic [1:0]  target;
      logic [21:0] mem_address;
      logic        mem_write;
      logic [7:0]  mem_write_data;
      logic        mirroring_horizontal;
   } lcpbm_rsp_type;

   typedef struct packed {
      logic [8:0] prg_bank_count;
      logic [5:0] chr_bank_count;
      logic       prg_ram_present;
   } cfg_type;

   typedef struct packed {
      kind_type    kind;
      logic [15:0] address;
      logic [7:0]  write_data;
   } work_type;

   function automatic logic [8:0] eff_prg_count(input logic [8:0] count);
      return (count > 9'(MAX_PRG_BANKS)) ? 9'(MAX_PRG_BANKS) : count;
   endfunction

   function automatic logic [5:0] eff_chr_count(input logic [5:0] count);
      return (count > 6'(MAX_CHR_BANKS)) ? 6'(MAX_CHR_BANKS) : count;
   endfunction

endpackage

[rtl/lcpbm_front.sv]
// front end: classifies each bus access into a work item
module lcpbm_front import lcpbm_pkg::*; (
   input  lcpbm_req_type req_item,
   input  cfg_type       cfg,
   output work_type      work
);

   logic [15:0] addr;
   logic        in_ram;

   assign addr   = req_item.address;
   assign in_ram = (addr inside {[16'h6000:16'h7FFF]});

   always_comb begin
      work.address    = req_item.address;
      work.write_data = req_item.write_data;
      work.kind       = KIND_IGNORE;
      case (op_type'(req_item.operation))
         OP_CPU_READ: begin
            if (in_ram) begin
               work.kind = cfg.prg_ram_present ? KIND_RAM_READ : KIND_OPEN_READ;
            end else if (addr[15]) begin
               if (eff_prg_count(cfg.prg_bank_count) == 9'd0) begin
                  work.kind = KIND_OPEN_READ;
               end else if (!addr[14]) begin
                  work.kind = KIND_PRG_SWITCH;
               end else begin
                  work.kind = KIND_PRG_FIXED;
               end
            end
         end
         OP_CPU_WRITE: begin
            if (in_ram) begin
               work.kind = cfg.prg_ram_present ? KIND_RAM_WRITE : KIND_IGNORE;
            end else if (addr >= 16'hA000) begin
               work.kind = KIND_REG_WRITE;
            end
         end
         OP_PPU_READ, OP_PPU_WRITE: begin
            if (addr < 16'h2000 && eff_chr_count(cfg.chr_bank_count) != 6'd0) begin
               work.kind = (req_item.operation == OP_PPU_READ) ? KIND_CHR_READ
                                                               : KIND_CHR_WRITE;
            end
         end
         default: work.kind = KIND_IGNORE;
      endcase
   end

endmodule

[rtl/lcpbm_queue.sv]
// short queue of classified items between front and back
module lcpbm_queue import lcpbm_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  work_type push_item,
   output logic     full,
   input  logic     pop,
   output work_type pop_item,
   output logic     empty
);

   work_type   slot_ff [QUEUE_DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign full     = (count_ff == 2'(QUEUE_DEPTH));
   assign empty    = (count_ff == 2'd0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_item = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

[rtl/lcpbm_back.sv]
// back end: bank state, bank modulo unit and result register
module lcpbm_back import lcpbm_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  cfg_type       cfg,
   input  work_type      q_item,
   input  logic          q_empty,
   output logic          q_pop,
   output lcpbm_rsp_type rsp_item,
   output logic          rsp_empty,
   input  logic          rsp_pop
);

   back_state_type state_ff, state_in;
   work_type       item_ff;
   logic [8:0]     div_ff, div_in;
   logic [8:0]     rem_ff, rem_in;
   logic [4:0]     dvd_ff, dvd_in;
   logic [2:0]     step_ff, step_in;

   logic [3:0]     prg_select_ff;
   logic [4:0]     low_fd_ff, low_fe_ff, high_fd_ff, high_fe_ff;
   logic           low_latch_ff, high_latch_ff, mirror_ff;

   lcpbm_rsp_type  out_ff, rsp_in;
   logic           out_valid_ff;
   logic           fire;
   logic           needs_div;
   logic [4:0]     chr_bank;
   logic [9:0]     trial;
   logic [2:0]     reg_sel;

   assign needs_div = (q_item.kind == KIND_PRG_SWITCH) || (q_item.kind == KIND_CHR_READ) ||
                      (q_item.kind == KIND_CHR_WRITE);
   assign reg_sel   = item_ff.address[14:12];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BACK_IDLE: begin
            if (!q_empty) begin
               state_in = needs_div ? BACK_DIVIDE : BACK_FINISH;
            end
         end
         BACK_DIVIDE: begin
            if (step_ff == 3'(DIV_STEPS - 1)) begin
               state_in = BACK_FINISH;
            end
         end
         BACK_FINISH: begin
            if (!out_valid_ff || rsp_pop) begin
               state_in = BACK_IDLE;
            end
         end
         default: state_in = BACK_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      q_pop = 1'b0;
      fire  = 1'b0;
      case (state_ff)
         BACK_IDLE:   q_pop = !q_empty;
         BACK_FINISH: fire  = !out_valid_ff || rsp_pop;
         default: begin
            q_pop = 1'b0;
            fire  = 1'b0;
         end
      endcase
   end

   // bank modulo datapath
   always_comb begin
      if (!q_item.address[12]) begin
         chr_bank = low_latch_ff ? low_fe_ff : low_fd_ff;
      end else begin
         chr_bank = high_latch_ff ? high_fe_ff : high_fd_ff;
      end
      trial   = {rem_ff, dvd_ff[4]};
      div_in  = div_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      step_in = step_ff;
      if (state_ff == BACK_IDLE) begin
         step_in = 3'd0;
         rem_in  = 9'd0;
         if (q_item.kind == KIND_PRG_SWITCH) begin
            div_in = eff_prg_count(cfg.prg_bank_count);
            dvd_in = {1'b0, prg_select_ff};
         end else if (q_item.kind == KIND_PRG_FIXED) begin
            div_in = eff_prg_count(cfg.prg_bank_count);
            rem_in = eff_prg_count(cfg.prg_bank_count) - 9'd1;
            dvd_in = 5'd0;
         end else begin
            div_in = {3'd0, eff_chr_count(cfg.chr_bank_count)};
            dvd_in = chr_bank;
         end
      end else if (state_ff == BACK_DIVIDE) begin
         step_in = step_ff + 3'd1;
         dvd_in  = {dvd_ff[3:0], 1'b0};
         if (trial >= {1'b0, div_ff}) begin
            rem_in = 9'(trial - {1'b0, div_ff});
         end else begin
            rem_in = trial[8:0];
         end
      end
   end

   // result of the finishing item
   always_comb begin
      rsp_in = '0;
      rsp_in.mirroring_horizontal = mirror_ff;
      if (item_ff.kind == KIND_REG_WRITE && reg_sel == REG_MIRROR) begin
         rsp_in.mirroring_horizontal = item_ff.write_data[0];
      end
      case (item_ff.kind)
         KIND_OPEN_READ: rsp_in.handled = 1'b1;
         KIND_RAM_READ, KIND_RAM_WRITE: begin
            rsp_in.handled     = (item_ff.kind == KIND_RAM_READ);
            rsp_in.target      = TGT_PRG_RAM;
            rsp_in.mem_address = {9'd0, item_ff.address[12:0]};
         end
         KIND_PRG_SWITCH, KIND_PRG_FIXED: begin
            rsp_in.handled     = 1'b1;
            rsp_in.target      = TGT_PRG_ROM;
            rsp_in.mem_address = {rem_ff[7:0], item_ff.address[13:0]};
         end
         KIND_CHR_READ, KIND_CHR_WRITE: begin
            rsp_in.handled     = (item_ff.kind == KIND_CHR_READ);
            rsp_in.target      = TGT_CHR;
            rsp_in.mem_address = {5'd0, rem_ff[4:0], item_ff.address[11:0]};
         end
         default: rsp_in.handled = 1'b0;
      endcase
      if (item_ff.kind == KIND_RAM_WRITE || item_ff.kind == KIND_CHR_WRITE) begin
         rsp_in.mem_write      = 1'b1;
         rsp_in.mem_write_data = item_ff.write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (fire) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_pop) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      div_ff  <= div_in;
      rem_ff  <= rem_in;
      dvd_ff  <= dvd_in;
      step_ff <= step_in;
      if (q_pop) begin
         item_ff <= q_item;
      end
      if (fire) begin
         out_ff <= rsp_in;
      end
   end

   // mapper registers and tile latches
   always_ff @(posedge clock) begin
      if (reset) begin
         prg_select_ff <= 4'd0;
         low_fd_ff     <= 5'd0;
         low_fe_ff     <= 5'd0;
         high_fd_ff    <= 5'd0;
         high_fe_ff    <= 5'd0;
         low_latch_ff  <= 1'b1;
         high_latch_ff <= 1'b1;
         mirror_ff     <= 1'b0;
      end else if (fire) begin
         if (item_ff.kind == KIND_REG_WRITE) begin
            case (reg_sel)
               REG_PRG_SELECT:  prg_select_ff <= item_ff.write_data[3:0];
               REG_CHR_LOW_FD:  low_fd_ff     <= item_ff.write_data[4:0];
               REG_CHR_LOW_FE:  low_fe_ff     <= item_ff.write_data[4:0];
               REG_CHR_HIGH_FD: high_fd_ff    <= item_ff.write_data[4:0];
               REG_CHR_HIGH_FE: high_fe_ff    <= item_ff.write_data[4:0];
               REG_MIRROR:      mirror_ff     <= item_ff.write_data[0];
               default:         mirror_ff     <= mirror_ff;
            endcase
         end else if (item_ff.kind == KIND_CHR_READ) begin
            if (item_ff.address inside {[16'h0FD8:16'h0FDF]}) begin
               low_latch_ff <= 1'b0;
            end else if (item_ff.address inside {[16'h0FE8:16'h0FEF]}) begin
               low_latch_ff <= 1'b1;
            end else if (item_ff.address inside {[16'h1FD8:16'h1FDF]}) begin
               high_latch_ff <= 1'b0;
            end else if (item_ff.address inside {[16'h1FE8:16'h1FEF]}) begin
               high_latch_ff <= 1'b1;
            end
         end
      end
   end

   assign rsp_item  = out_ff;
   assign rsp_empty = !out_valid_ff;

`ifndef SYNTH
   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == BACK_DIVIDE |-> step_ff < 3'(DIV_STEPS))
      else $error("modulo step counter overran");

   a_rem_below_div: assert property (@(posedge clock) disable iff (reset)
      state_ff == BACK_DIVIDE |-> rem_ff < div_ff)
      else $error("partial remainder not below bank count");

   a_result_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(state_ff == BACK_FINISH))
      else $error("result appeared without a finishing item");

   a_divide_ends: assert property (@(posedge clock) disable iff (reset)
      state_ff == BACK_DIVIDE && step_ff == 3'(DIV_STEPS - 1) |=> state_ff == BACK_FINISH)
      else $error("modulo did not hand over to finish");
`endif

endmodule

[rtl/latched_chr_prg_bank_mapper.sv]
// top level of the latched chr/prg bank mapper
// Bank mapper with tile-triggered CHR latches. Accesses enter through a queue-like
// port (push/full) and results leave through one (empty/pop); the result register
// lets the next access be taken while a result still waits. The front classifies
// each access into a two-entry queue; the back owns the bank registers and latches.
// The back reduces a bank modulo the bank count for switchable PRG reads and all CHR
// accesses: the remainder unit works one dividend bit per cycle over 5 bits. Results
// come out in access order. Bank count registers are to be written through the csr
// port only while the block is idle; the block itself does not enforce this.
module latched_chr_prg_bank_mapper import lcpbm_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_push,
   input  lcpbm_req_type req_item,
   output logic          req_full,
   output logic          rsp_empty,
   input  logic          rsp_pop,
   output lcpbm_rsp_type rsp_item,
   input  logic          csr_write_enable,
   input  logic [1:0]    csr_index,
   input  logic [8:0]    csr_write_data
);

   cfg_type  cfg_ff;
   work_type front_work, q_item;
   logic     q_empty, q_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_PRG_BANK_COUNT:  cfg_ff.prg_bank_count  <= csr_write_data;
            CSR_CHR_BANK_COUNT:  cfg_ff.chr_bank_count  <= csr_write_data[5:0];
            CSR_PRG_RAM_PRESENT: cfg_ff.prg_ram_present <= csr_write_data[0];
            default:             cfg_ff                 <= cfg_ff;
         endcase
      end
   end

   lcpbm_front u_front (
      .req_item (req_item),
      .cfg      (cfg_ff),
      .work     (front_work)
   );

   lcpbm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_item (front_work),
      .full      (req_full),
      .pop       (q_pop),
      .pop_item  (q_item),
      .empty     (q_empty)
   );

   lcpbm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_item    (q_item),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .rsp_item  (rsp_item),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop)
   );

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps
// testbench for latched_chr_prg_bank_mapper: random and directed bus accesses against a predictor
module tb_top import lcpbm_pkg::*; ();

   localparam int unsigned STALL_LIMIT = 4000;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_push = 1'b0;
   lcpbm_req_type req_item = '0;
   logic          req_full;
   logic          rsp_empty;
   logic          rsp_pop = 1'b0;
   lcpbm_rsp_type rsp_item;
   logic          csr_write_enable = 1'b0;
   logic [1:0]    csr_index = '0;
   logic [8:0]    csr_write_data = '0;

   latched_chr_prg_bank_mapper dut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_item         (req_item),
      .req_full         (req_full),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_item         (rsp_item),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // mapper state as predicted
   logic [8:0] prg_count;
   logic [5:0] chr_count;
   logic       ram_on;
   logic [3:0] prg_sel;
   logic [4:0] lo_fd, lo_fe, hi_fd, hi_fe;
   logic       latch_lo, latch_hi, mirror;

   lcpbm_req_type access_q[$];
   lcpbm_rsp_type mapped_q[$];

   logic        quiet = 1'b0;
   int unsigned err_count = 0;
   int unsigned op_count[4] = '{0, 0, 0, 0};
   int unsigned cfg_count = 0;
   int unsigned result_count = 0;
   int unsigned gap_left = 0;
   int unsigned stall_left = 0;
   int unsigned idle_cycles = 0;

   function automatic lcpbm_rsp_type map_access(lcpbm_req_type a);
      lcpbm_rsp_type r;
      int unsigned   n;
      int unsigned   bank;
      logic [15:0]   adr;
      r = '0;
      adr = a.address;
      case (op_type'(a.operation))
         OP_CPU_READ: begin
            if (adr >= 16'h6000 && adr <= 16'h7FFF) begin
               r.handled = 1'b1;
               if (ram_on) begin
                  r.target = TGT_PRG_RAM;
                  r.mem_address = 22'(adr - 16'h6000);
               end
            end else if (adr >= 16'h8000) begin
               n = (prg_count > MAX_PRG_BANKS) ? MAX_PRG_BANKS : prg_count;
               r.handled = 1'b1;
               if (n != 0) begin
                  bank = (adr < 16'hC000) ? prg_sel : n - 1;
                  bank = bank % n;
                  r.target = TGT_PRG_ROM;
                  r.mem_address = 22'(bank * 16384 + adr[13:0]);
               end
            end
         end
         OP_CPU_WRITE: begin
            if (adr >= 16'h6000 && adr <= 16'h7FFF) begin
               if (ram_on) begin
                  r.target = TGT_PRG_RAM;
                  r.mem_address = 22'(adr - 16'h6000);
                  r.mem_write = 1'b1;
                  r.mem_write_data = a.write_data;
               end
            end else if (adr >= 16'hA000) begin
               case (adr[14:12])
                  REG_PRG_SELECT:  prg_sel = a.write_data[3:0];
                  REG_CHR_LOW_FD:  lo_fd = a.write_data[4:0];
                  REG_CHR_LOW_FE:  lo_fe = a.write_data[4:0];
                  REG_CHR_HIGH_FD: hi_fd = a.write_data[4:0];
                  REG_CHR_HIGH_FE: hi_fe = a.write_data[4:0];
                  REG_MIRROR:      mirror = a.write_data[0];
                  default: ;
               endcase
            end
         end
         default: begin
            n = (chr_count > MAX_CHR_BANKS) ? MAX_CHR_BANKS : chr_count;
            if (adr < 16'h2000 && n != 0) begin
               if (!adr[12]) bank = latch_lo ? lo_fe : lo_fd;
               else bank = latch_hi ? hi_fe : hi_fd;
               bank = bank % n;
               r.target = TGT_CHR;
               r.mem_address = 22'(bank * 4096 + adr[11:0]);
               if (a.operation == OP_PPU_READ) begin
                  r.handled = 1'b1;
                  if (adr >= 16'h0FD8 && adr <= 16'h0FDF) latch_lo = 1'b0;
                  else if (adr >= 16'h0FE8 && adr <= 16'h0FEF) latch_lo = 1'b1;
                  else if (adr >= 16'h1FD8 && adr <= 16'h1FDF) latch_hi = 1'b0;
                  else if (adr >= 16'h1FE8 && adr <= 16'h1FEF) latch_hi = 1'b1;
               end else begin
                  r.mem_write = 1'b1;
                  r.mem_write_data = a.write_data;
               end
            end
         end
      endcase
      r.mirroring_horizontal = mirror;
      return r;
   endfunction

   function automatic string show_map(lcpbm_rsp_type r);
      return $sformatf("handled=%0d target=%0d addr=%06h wr=%0d data=%02h mirror=%0d",
                       r.handled, r.target, r.mem_address, r.mem_write,
                       r.mem_write_data, r.mirroring_horizontal);
   endfunction

   function automatic void note_error(string msg);
      err_count++;
      if (err_count <= 10) $display("ERROR %0t: %s", $realtime, msg);
   endfunction

   function automatic lcpbm_req_type random_access();
      lcpbm_req_type a;
      int unsigned   pick;
      logic [15:0]   base;
      a.write_data = 8'($urandom);
      pick = $urandom_range(0, 15);
      case (pick)
         0, 1, 2: begin
            a.operation = OP_CPU_WRITE;
            a.address = 16'($urandom_range(16'hA000, 16'hFFFF));
         end
         3, 4: begin
            a.operation = OP_CPU_READ;
            a.address = 16'($urandom_range(16'h8000, 16'hFFFF));
         end
         5: begin
            a.operation = $urandom_range(0, 1) ? OP_CPU_WRITE : OP_CPU_READ;
            a.address = 16'($urandom_range(16'h5FFF, 16'h8000));
         end
         6, 7, 8: begin
            case ($urandom_range(0, 3))
               0: base = 16'h0FD8;
               1: base = 16'h0FE8;
               2: base = 16'h1FD8;
               default: base = 16'h1FE8;
            endcase
            a.operation = OP_PPU_READ;
            a.address = base + 16'($urandom_range(0, 9)) - 16'd1;
         end
         9, 10, 11: begin
            a.operation = OP_PPU_READ;
            a.address = 16'($urandom_range(0, 16'h1FFF));
         end
         12: begin
            a.operation = OP_PPU_WRITE;
            a.address = 16'($urandom_range(0, 16'h1FFF));
         end
         default: begin
            a.operation = 2'($urandom);
            a.address = 16'($urandom);
         end
      endcase
      return a;
   endfunction

   task automatic add(op_type op, logic [15:0] adr, logic [7:0] data);
      lcpbm_req_type a;
      a.operation = op;
      a.address = adr;
      a.write_data = data;
      access_q.push_back(a);
   endtask

   task automatic write_reg(csr_index_type idx, logic [8:0] val);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= val;
      case (idx)
         CSR_PRG_BANK_COUNT: prg_count = val;
         CSR_CHR_BANK_COUNT: chr_count = val[5:0];
         default:            ram_on = val[0];
      endcase
   endtask

   task automatic set_config(logic [8:0] prg, logic [5:0] chr, logic ram);
      write_reg(CSR_PRG_BANK_COUNT, prg);
      write_reg(CSR_CHR_BANK_COUNT, 9'(chr));
      write_reg(CSR_PRG_RAM_PRESENT, 9'(ram));
      @(posedge clock);
      csr_write_enable <= 1'b0;
      cfg_count++;
   endtask

   task automatic drain();
      @(posedge clock);
      while (access_q.size() != 0 || mapped_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // driver
   always @(posedge clock) begin
      logic hold;
      if (reset) begin
         req_push <= 1'b0;
         gap_left = 0;
      end else begin
         hold = req_push && req_full;
         if (req_push && !req_full) begin
            mapped_q.push_back(map_access(req_item));
            op_count[req_item.operation]++;
            void'(access_q.pop_front());
         end
         if (!hold) begin
            if (gap_left > 0) begin
               gap_left--;
               req_push <= 1'b0;
            end else if (!quiet && access_q.size() != 0 && $urandom_range(0, 7) == 0) begin
               gap_left = $urandom_range(1, 6) - 1;
               req_push <= 1'b0;
            end else if (access_q.size() != 0) begin
               req_push <= 1'b1;
               req_item <= access_q[0];
            end else begin
               req_push <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      lcpbm_rsp_type want;
      if (reset) begin
         rsp_pop <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            result_count++;
            if (mapped_q.size() == 0) begin
               note_error($sformatf("unexpected item: %s", show_map(rsp_item)));
            end else begin
               want = mapped_q.pop_front();
               if (rsp_item.handled !== want.handled || rsp_item.target !== want.target ||
                   rsp_item.mem_address !== want.mem_address ||
                   rsp_item.mem_write !== want.mem_write ||
                   rsp_item.mem_write_data !== want.mem_write_data ||
                   rsp_item.mirroring_horizontal !== want.mirroring_horizontal)
                  note_error($sformatf("mismatch\n   expected %s\n   actual   %s",
                                       show_map(want), show_map(rsp_item)));
            end
         end
         if (quiet) begin
            rsp_pop <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_pop <= 1'b0;
         end else if ($urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 6) - 1;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty) ||
          (access_q.size() == 0 && mapped_q.size() == 0)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout: %0d items still waiting", mapped_q.size());
            $display("tb_top NOT OK");
            $finish;
         end
      end
   end

   initial begin
      prg_count = '0;
      chr_count = '0;
      ram_on = 1'b0;
      prg_sel = '0;
      lo_fd = '0;
      lo_fe = '0;
      hi_fd = '0;
      hi_fe = '0;
      latch_lo = 1'b1;
      latch_hi = 1'b1;
      mirror = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // no prg, no chr, no work ram
      add(OP_CPU_READ, 16'h8000, 8'h00);
      add(OP_CPU_READ, 16'h6000, 8'h00);
      add(OP_CPU_WRITE, 16'h6000, 8'h11);
      add(OP_PPU_READ, 16'h0000, 8'h00);
      add(OP_CPU_READ, 16'h5FFF, 8'h00);
      drain();

      // counts above the maximum
      set_config(9'd300, 6'd63, 1'b1);
      add(OP_CPU_WRITE, 16'hA000, 8'hFF);
      add(OP_CPU_WRITE, 16'hB000, 8'hFF);
      add(OP_CPU_WRITE, 16'hC000, 8'h1E);
      add(OP_CPU_WRITE, 16'hD000, 8'h03);
      add(OP_CPU_WRITE, 16'hE000, 8'hFF);
      add(OP_CPU_WRITE, 16'hF000, 8'h01);
      add(OP_CPU_WRITE, 16'h8000, 8'h07);
      add(OP_CPU_READ, 16'h8000, 8'h00);
      add(OP_CPU_READ, 16'hBFFF, 8'h00);
      add(OP_CPU_READ, 16'hFFFF, 8'h00);
      add(OP_CPU_WRITE, 16'h7FFF, 8'hA5);
      add(OP_CPU_READ, 16'h7FFF, 8'h00);
      add(OP_PPU_READ, 16'h0FD8, 8'h00);
      add(OP_PPU_READ, 16'h0000, 8'h00);
      add(OP_PPU_READ, 16'h0FEF, 8'h00);
      add(OP_PPU_READ, 16'h1FDF, 8'h00);
      add(OP_PPU_READ, 16'h1FFF, 8'h00);
      add(OP_PPU_READ, 16'h1FE8, 8'h00);
      add(OP_PPU_WRITE, 16'h1ABC, 8'h5A);
      add(OP_PPU_READ, 16'h2000, 8'h00);
      add(OP_PPU_WRITE, 16'hFFFF, 8'hC3);
      drain();

      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: set_config(9'd1, 6'd1, 1'b1);
            1: set_config(9'd256, 6'd32, 1'b1);
            2: set_config(9'd511, 6'd63, 1'b0);
            3: set_config(9'd0, 6'd0, 1'b1);
            4: set_config(9'd255, 6'd31, 1'b0);
            default: set_config(9'($urandom_range(0, 20)), 6'($urandom_range(0, 40)),
                                1'($urandom_range(0, 1)));
         endcase
         quiet = (ph == 7);
         for (int i = 0; i < 250; i++) access_q.push_back(random_access());
         drain();
      end

      repeat (20) @(posedge clock);
      if (mapped_q.size() != 0) note_error($sformatf("%0d items never came", mapped_q.size()));
      $display("covered %0d accesses: %0d cpu reads, %0d cpu writes, %0d ppu reads, %0d ppu writes",
               result_count, op_count[0], op_count[1], op_count[2], op_count[3]);
      $display("over %0d bank count settings, %0d mismatches", cfg_count, err_count);
      if (err_count == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule
